// ----- design/i2crb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2crb_pkg;

    // bank geometry
    localparam int BANK_SIZE = 39;
    localparam int BANK_AW   = $clog2(BANK_SIZE);
    localparam logic [7:0] BANK_SIZE_B = 8'(BANK_SIZE);

    // fixed register locations
    localparam int REG_TOP_LEDS    = 4;
    localparam int REG_BOT_LEDS    = 17;
    localparam int REG_TOP_CLICKS  = 30;
    localparam int REG_BOT_CLICKS  = 31;
    localparam int REG_TOP_PRESSES = 32;
    localparam int REG_BOT_PRESSES = 33;
    localparam int REG_TOP_SETTING = 34;
    localparam int REG_BOT_SETTING = 35;
    localparam int REG_AUTOSET     = 36;
    localparam int REG_WDT         = 37;
    localparam int REG_FW          = 38;
    localparam logic [7:0] REG_WDT_B = 8'(REG_WDT);

    localparam logic [7:0] FW_VERSION = 8'h12;

    // dial arithmetic
    localparam int LED_COUNT = 9;
    localparam int LED_MID   = 4;
    localparam logic [7:0] STEP = 8'd25;
    localparam logic signed [7:0] SETTING_MAX = 8'sd100;
    localparam logic signed [7:0] SETTING_MIN = -8'sd100;
    localparam logic signed [7:0] LOW_THRESH  [4] = '{-8'sd100, -8'sd70, -8'sd50, -8'sd25};
    localparam logic signed [7:0] HIGH_THRESH [4] = '{8'sd25, 8'sd50, 8'sd75, 8'sd100};

    // configuration port
    localparam int CFG_AW = 2;

    typedef enum logic [CFG_AW-1:0] {
        CFG_COLOR_LOW  = 2'd0,
        CFG_COLOR_OFF  = 2'd1,
        CFG_COLOR_MID  = 2'd2,
        CFG_COLOR_HIGH = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_START = 2'd1,
        MODE_DATA  = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] low;
        logic [7:0] off;
        logic [7:0] mid;
        logic [7:0] high;
    } t_colors;

    typedef struct packed {
        logic [7:0] read_data;
        logic       wdt_kick;
    } t_result;

endpackage

`default_nettype wire

// ----- design/i2crb_dial.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2crb_dial (
    input  wire logic [7:0]       i_setting,
    input  wire logic [7:0]       i_clicks,
    input  wire logic [7:0]       i_prev_clicks,
    input  wire logic [7:0]       i_presses,
    input  wire logic [7:0]       i_prev_presses,
    input  wire i2crb_pkg::t_colors i_colors,
    output logic [7:0]            o_setting,
    output logic [i2crb_pkg::LED_COUNT-1:0][7:0] o_leds
);

    logic signed [7:0] stepped;
    logic signed [7:0] clamped;

    // click step with 8-bit wrap, press reset, then clamp
    always_comb begin
        stepped = $signed(i_setting);
        if ($signed(i_clicks) < $signed(i_prev_clicks)) begin
            stepped = $signed(i_setting - i2crb_pkg::STEP);
        end else if ($signed(i_clicks) > $signed(i_prev_clicks)) begin
            stepped = $signed(i_setting + i2crb_pkg::STEP);
        end
        if (i_presses != i_prev_presses) begin
            stepped = '0;
        end
        clamped = stepped;
        if (stepped < i2crb_pkg::SETTING_MIN) begin
            clamped = i2crb_pkg::SETTING_MIN;
        end
        if (stepped > i2crb_pkg::SETTING_MAX) begin
            clamped = i2crb_pkg::SETTING_MAX;
        end
    end

    assign o_setting = $unsigned(clamped);

    // led ring by threshold on the clamped setting
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_leds[i] = (clamped <= i2crb_pkg::LOW_THRESH[i]) ?
                        i_colors.low : i_colors.off;
            o_leds[i2crb_pkg::LED_MID+1+i] = (clamped >= i2crb_pkg::HIGH_THRESH[i]) ?
                        i_colors.high : i_colors.off;
        end
        o_leds[i2crb_pkg::LED_MID] = i_colors.mid;
    end

endmodule

`default_nettype wire

// ----- design/i2crb_bank.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2crb_bank (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire i2crb_pkg::t_mode   i_mode,
    input  wire logic [7:0]         i_data,
    input  wire i2crb_pkg::t_colors i_colors,
    output i2crb_pkg::t_result      o_result
);

    logic [7:0] r_bank [i2crb_pkg::BANK_SIZE];
    logic [7:0] n_bank [i2crb_pkg::BANK_SIZE];
    logic [7:0] r_ptr, n_ptr;
    logic       r_expect_addr, n_expect_addr;
    logic [7:0] r_prev_top_clicks, n_prev_top_clicks;
    logic [7:0] r_prev_bot_clicks, n_prev_bot_clicks;
    logic [7:0] r_prev_top_presses, n_prev_top_presses;
    logic [7:0] r_prev_bot_presses, n_prev_bot_presses;

    logic       in_range;
    logic [7:0] rd_byte;
    logic [7:0] top_set_new;
    logic [7:0] bot_set_new;
    logic [i2crb_pkg::LED_COUNT-1:0][7:0] top_leds;
    logic [i2crb_pkg::LED_COUNT-1:0][7:0] bot_leds;

    // dial units read their fixed bank bytes
    i2crb_dial u_top_dial (
        .i_setting      (r_bank[i2crb_pkg::REG_TOP_SETTING]),
        .i_clicks       (r_bank[i2crb_pkg::REG_TOP_CLICKS]),
        .i_prev_clicks  (r_prev_top_clicks),
        .i_presses      (r_bank[i2crb_pkg::REG_TOP_PRESSES]),
        .i_prev_presses (r_prev_top_presses),
        .i_colors       (i_colors),
        .o_setting      (top_set_new),
        .o_leds         (top_leds)
    );

    i2crb_dial u_bot_dial (
        .i_setting      (r_bank[i2crb_pkg::REG_BOT_SETTING]),
        .i_clicks       (r_bank[i2crb_pkg::REG_BOT_CLICKS]),
        .i_prev_clicks  (r_prev_bot_clicks),
        .i_presses      (r_bank[i2crb_pkg::REG_BOT_PRESSES]),
        .i_prev_presses (r_prev_bot_presses),
        .i_colors       (i_colors),
        .o_setting      (bot_set_new),
        .o_leds         (bot_leds)
    );

    // pointer read port
    assign in_range = (r_ptr < i2crb_pkg::BANK_SIZE_B);
    assign rd_byte  = in_range ? r_bank[r_ptr[i2crb_pkg::BANK_AW-1:0]] : 8'd0;

    // next state for one word
    always_comb begin
        n_bank             = r_bank;
        n_ptr              = r_ptr;
        n_expect_addr      = r_expect_addr;
        n_prev_top_clicks  = r_prev_top_clicks;
        n_prev_bot_clicks  = r_prev_bot_clicks;
        n_prev_top_presses = r_prev_top_presses;
        n_prev_bot_presses = r_prev_bot_presses;
        o_result           = '0;
        unique case (i_mode)
            i2crb_pkg::MODE_READ: begin
                o_result.read_data = rd_byte;
                n_ptr = r_ptr + 8'd1;
            end
            i2crb_pkg::MODE_START: begin
                n_expect_addr = 1'b1;
            end
            i2crb_pkg::MODE_DATA: begin
                if (r_expect_addr) begin
                    n_ptr         = i_data;
                    n_expect_addr = 1'b0;
                    if (i_data == i2crb_pkg::REG_WDT_B) begin
                        n_bank[i2crb_pkg::REG_WDT] = r_bank[i2crb_pkg::REG_WDT] + 8'd1;
                        o_result.wdt_kick = 1'b1;
                    end
                end else begin
                    if (in_range) begin
                        n_bank[r_ptr[i2crb_pkg::BANK_AW-1:0]] = i_data;
                    end
                    n_ptr = r_ptr + 8'd1;
                end
            end
            i2crb_pkg::MODE_TICK: begin
                n_bank[i2crb_pkg::REG_FW]          = i2crb_pkg::FW_VERSION;
                n_bank[i2crb_pkg::REG_TOP_SETTING] = top_set_new;
                n_bank[i2crb_pkg::REG_BOT_SETTING] = bot_set_new;
                n_prev_top_clicks  = r_bank[i2crb_pkg::REG_TOP_CLICKS];
                n_prev_bot_clicks  = r_bank[i2crb_pkg::REG_BOT_CLICKS];
                n_prev_top_presses = r_bank[i2crb_pkg::REG_TOP_PRESSES];
                n_prev_bot_presses = r_bank[i2crb_pkg::REG_BOT_PRESSES];
                if (r_bank[i2crb_pkg::REG_AUTOSET] != 8'd0) begin
                    for (int i = 0; i < i2crb_pkg::LED_COUNT; i++) begin
                        n_bank[i2crb_pkg::REG_TOP_LEDS+i] = top_leds[i];
                        n_bank[i2crb_pkg::REG_BOT_LEDS+i] = bot_leds[i];
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // state registers, updated once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < i2crb_pkg::BANK_SIZE; i++) begin
                r_bank[i] <= '0;
            end
            r_ptr              <= '0;
            r_expect_addr      <= 1'b0;
            r_prev_top_clicks  <= '0;
            r_prev_bot_clicks  <= '0;
            r_prev_top_presses <= '0;
            r_prev_bot_presses <= '0;
        end else if (i_fire) begin
            r_bank             <= n_bank;
            r_ptr              <= n_ptr;
            r_expect_addr      <= n_expect_addr;
            r_prev_top_clicks  <= n_prev_top_clicks;
            r_prev_bot_clicks  <= n_prev_bot_clicks;
            r_prev_top_presses <= n_prev_top_presses;
            r_prev_bot_presses <= n_prev_bot_presses;
        end
    end

    // firmware byte holds the version after any tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_mode == i2crb_pkg::MODE_TICK)
        |=> r_bank[i2crb_pkg::REG_FW] == i2crb_pkg::FW_VERSION)
        else $error("fw version not written by tick");

    // settings stay inside the clamp window after a tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_mode == i2crb_pkg::MODE_TICK)
        |=> ($signed(r_bank[i2crb_pkg::REG_TOP_SETTING]) >= i2crb_pkg::SETTING_MIN)
         && ($signed(r_bank[i2crb_pkg::REG_TOP_SETTING]) <= i2crb_pkg::SETTING_MAX)
         && ($signed(r_bank[i2crb_pkg::REG_BOT_SETTING]) >= i2crb_pkg::SETTING_MIN)
         && ($signed(r_bank[i2crb_pkg::REG_BOT_SETTING]) <= i2crb_pkg::SETTING_MAX))
        else $error("dial setting outside clamp window");

    // the address byte loads the pointer and clears the address phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_mode == i2crb_pkg::MODE_DATA) && r_expect_addr
        |=> !r_expect_addr && (r_ptr == $past(i_data)))
        else $error("address byte not taken as pointer");

endmodule

`default_nettype wire

// ----- design/i2c_register_bank_dial_controller_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Register bank behind a serial-bus target, with the periodic dial work.
// Input channel (i_in_valid / o_in_stall) carries one word per bus event:
// i_mode selects read request, write start, data byte or periodic tick,
// i_data is the received byte. Output channel (o_out_valid / i_out_stall)
// returns one word per input word: o_read_data for a read, zero otherwise,
// and o_wdt_kick when an address byte selects the watchdog register.
// Each word is registered on entry, handled by one pass of logic over the
// flop-based bank, and lands in the output register; one word is taken per
// cycle while the receiver does not stall. The input register keeps
// accepting while a finished result waits; the input side stalls only when
// both the input and output registers are full and the receiver stalls.
// Color codes are written through i_cfg_we / i_cfg_idx / i_cfg_data only
// while the block is idle; the user must keep to this, the block itself
// does not enforce it. Reset (synchronous, active low) clears the bank,
// pointer, dial history and both handshakes and reloads default colors.
module i2c_register_bank_dial_controller_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_mode,
    input  wire logic [7:0]                   i_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [7:0]                        o_read_data,
    output logic                              o_wdt_kick,
    input  wire logic                         i_cfg_we,
    input  wire logic [i2crb_pkg::CFG_AW-1:0] i_cfg_idx,
    input  wire logic [7:0]                   i_cfg_data
);

    logic                 r_in_valid;
    i2crb_pkg::t_mode     r_in_mode;
    logic [7:0]           r_in_data;
    logic                 r_out_valid;
    i2crb_pkg::t_result   r_out;
    i2crb_pkg::t_colors   r_colors;
    i2crb_pkg::t_result   result;
    logic                 fire;
    logic                 in_accept;

    // handshake control
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors.low  <= 8'd4;
            r_colors.off  <= 8'd0;
            r_colors.mid  <= 8'd2;
            r_colors.high <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i2crb_pkg::t_cfg_idx'(i_cfg_idx))
                i2crb_pkg::CFG_COLOR_LOW:  r_colors.low  <= i_cfg_data;
                i2crb_pkg::CFG_COLOR_OFF:  r_colors.off  <= i_cfg_data;
                i2crb_pkg::CFG_COLOR_MID:  r_colors.mid  <= i_cfg_data;
                i2crb_pkg::CFG_COLOR_HIGH: r_colors.high <= i_cfg_data;
                default:                   r_colors      <= r_colors;
            endcase
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (in_accept) begin
            r_in_mode <= i2crb_pkg::t_mode'(i_mode);
            r_in_data <= i_data;
        end
    end

    i2crb_bank u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_mode   (r_in_mode),
        .i_data   (r_in_data),
        .i_colors (r_colors),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_wdt_kick  = r_out.wdt_kick;

    // input side stalls only with both registers full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // read data is zero for every word that is not a read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in_mode != i2crb_pkg::MODE_READ) |=> o_read_data == 8'd0)
        else $error("nonzero read data for a non-read word");

    // kick only follows a data byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in_mode != i2crb_pkg::MODE_DATA) |=> !o_wdt_kick)
        else $error("watchdog kick without a data byte");

endmodule

`default_nettype wire
